// File: rtl/trnm_pkg.sv
// shared types, codes and helpers for the tower reject neighbour map
// no dependencies; imported by every module of the block
package trnm_pkg;

   localparam int NUM_SECTORS  = 8;
   localparam int SECTOR_W     = 3;
   localparam int MASK_W       = 21;
   localparam int MAP_W        = 32;
   localparam int COUNT_W      = 16;
   localparam int TOWER_Z_W    = 7;
   localparam int TOWER_Y_W    = 6;
   localparam int ROW_SPAN     = 5;
   localparam int TOP_ROW_BASE = 18;
   localparam int STEP_W       = 3;
   localparam logic [SECTOR_W-1:0] FIRST_GLASS = 3'd6;
   localparam logic [STEP_W-1:0]   LAST_STEP   = 3'd5;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_MARK  = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_QUERY,
      ST_DONE
   } state_type;

   // software sector (arm * 4 + arm_sector) to hardware sector
   function automatic logic [SECTOR_W-1:0] sector_map(input logic [SECTOR_W-1:0] sw);
      logic [SECTOR_W-1:0] hw;
      unique case (sw)
         3'd0:    hw = 3'd0;
         3'd1:    hw = 3'd1;
         3'd2:    hw = 3'd2;
         3'd3:    hw = 3'd3;
         3'd4:    hw = 3'd6;
         3'd5:    hw = 3'd7;
         3'd6:    hw = 3'd4;
         default: hw = 3'd5;
      endcase
      return hw;
   endfunction

   // place a five-tower y window of neighbour row k (dz = k - 2) into the mask
   function automatic logic [MASK_W-1:0] place_row(input logic [ROW_SPAN-1:0] w,
                                                   input logic [STEP_W-1:0] k);
      logic [MASK_W-1:0] m;
      m = '0;
      for (int kk = 0; kk < ROW_SPAN; kk++) begin
         if (k == STEP_W'(kk)) begin
            for (int j = 1; j <= 3; j++) begin
               m[3 + ROW_SPAN*(j-1) + kk] = w[j];
            end
            // corners of the 5x5 are left out
            if (kk >= 1 && kk <= 3) begin
               m[kk-1]                = w[0];
               m[TOP_ROW_BASE + kk-1] = w[ROW_SPAN-1];
            end
         end
      end
      return m;
   endfunction

endpackage

// File: rtl/trnm_bitmap.sv
// bad-tower bitmap storage: one row of y bits per sector and z
// single write port, single registered read port; uses trnm_pkg
module trnm_bitmap
   import trnm_pkg::*;
#(
   parameter int ADDR_W = 10,
   parameter int ROW_W  = 48
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [ROW_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [ROW_W-1:0]  rd_data
);

   logic [ROW_W-1:0] mem [(1 << ADDR_W)];
   logic [ROW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/trnm_window.sv
// shared shift unit: pulls the y-2..y+2 window out of one bitmap row
// and places it into the neighbour mask; uses trnm_pkg
module trnm_window
   import trnm_pkg::*;
#(
   parameter int ROW_W = 48
) (
   input  logic [ROW_W-1:0]     row,
   input  logic                 row_ok,
   input  logic [TOWER_Y_W-1:0] tower_y,
   input  logic [STEP_W-1:0]    step,
   output logic [MASK_W-1:0]    contrib
);

   logic [ROW_W+3:0]    ext;
   logic [ROW_W+3:0]    shifted;
   logic [ROW_SPAN-1:0] win;

   always_comb begin
      // two zero towers on each side cover y-2 below 0 and y+2 past the row
      ext     = {2'b00, row, 2'b00};
      shifted = ext >> tower_y;
      win     = row_ok ? shifted[ROW_SPAN-1:0] : '0;
      contrib = place_row(win, step);
   end

endmodule

// File: rtl/tower_reject_neighbor_map.sv
// Bad-tower map over 8 hardware sectors, one bit per tower. A mark does a read,
// modify, write of one bitmap row. A query reads the five neighbour rows z-2..z+2
// one per cycle through the single read port of the bitmap memory, each row passing
// the shared window shifter in the cycle after its read. An out-of-range item or an
// unused op goes straight to the done state. A clear, and the clearing pass after
// reset, sweeps all 8 * 2^clog2(MAX_Z_TOWERS) rows of the memory (1024 at the
// defaults); no transaction is accepted meanwhile. Each result is held in an output
// register until taken.
// uses trnm_pkg, trnm_bitmap and trnm_window
module tower_reject_neighbor_map
   import trnm_pkg::*;
#(
   parameter int MAX_Z_TOWERS   = 96,
   parameter int MAX_Y_TOWERS   = 48,
   parameter int SCINT_Z_TOWERS = 72,
   parameter int SCINT_Y_TOWERS = 36
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_op,
   input  logic [SECTOR_W-1:0]  req_load_sector,
   input  logic                 req_arm,
   input  logic [1:0]           req_arm_sector,
   input  logic [TOWER_Z_W-1:0] req_tower_z,
   input  logic [TOWER_Y_W-1:0] req_tower_y,
   input  logic [MAP_W-1:0]     req_prior_deadmap,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [MASK_W-1:0]    rsp_neighbor_mask,
   output logic [MAP_W-1:0]     rsp_merged_map,
   output logic                 rsp_to_deadmap,
   output logic [SECTOR_W-1:0]  rsp_hw_sector,
   output logic [COUNT_W-1:0]   rsp_bad_count,
   output logic                 rsp_range_error
);

   localparam int ZW     = $clog2(MAX_Z_TOWERS);
   localparam int ADDR_W = SECTOR_W + ZW;
   localparam int ROW_W  = MAX_Y_TOWERS;
   localparam logic [7:0] GLASS_Z = 8'(MAX_Z_TOWERS);
   localparam logic [7:0] SCINT_Z = 8'(SCINT_Z_TOWERS);
   localparam logic [6:0] GLASS_Y = 7'(MAX_Y_TOWERS);
   localparam logic [6:0] SCINT_Y = 7'(SCINT_Y_TOWERS);

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]    clr_addr_ff, clr_addr_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 reply_ff, reply_in;
   logic [1:0]           op_ff, op_in;
   logic [SECTOR_W-1:0]  sec_ff, sec_in;
   logic [TOWER_Z_W-1:0] z_ff, z_in;
   logic [TOWER_Y_W-1:0] y_ff, y_in;
   logic [MAP_W-1:0]     prior_ff, prior_in;
   logic                 err_ff, err_in;
   logic [MASK_W-1:0]    mask_ff, mask_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]    rsp_mask_ff;
   logic [MAP_W-1:0]     rsp_merged_ff;
   logic                 rsp_dead_ff;
   logic [SECTOR_W-1:0]  rsp_sec_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic                 rsp_err_ff;

   logic                 accept;
   logic                 load_rsp;
   logic [SECTOR_W-1:0]  new_sec;
   logic                 new_glass;
   logic                 new_in_grid;
   logic                 cur_glass;
   logic [7:0]           cur_zsize;
   logic [8:0]           zn_issue;
   logic [8:0]           zn_acc;
   logic [STEP_W-1:0]    step_acc;
   logic                 acc_ok;
   logic                 is_query;

   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [ROW_W-1:0]     wr_data;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ROW_W-1:0]     rd_data;
   logic [MASK_W-1:0]    contrib;

   // request decode
   always_comb begin
      new_sec     = (op_type'(req_op) == OP_MARK) ? req_load_sector
                                                  : sector_map({req_arm, req_arm_sector});
      new_glass   = (new_sec >= FIRST_GLASS);
      new_in_grid = ({1'b0, req_tower_z} < (new_glass ? GLASS_Z : SCINT_Z)) &&
                    ({1'b0, req_tower_y} < (new_glass ? GLASS_Y : SCINT_Y));
      accept      = (state_ff == ST_IDLE) && req_valid;
      load_rsp    = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   // neighbour row addressing for the query sweep
   always_comb begin
      cur_glass = (sec_ff >= FIRST_GLASS);
      cur_zsize = cur_glass ? GLASS_Z : SCINT_Z;
      zn_issue  = {2'b00, z_ff} + {6'b0, step_ff} - 9'd2;
      step_acc  = step_ff - 3'd1;
      zn_acc    = {2'b00, z_ff} + {6'b0, step_acc} - 9'd2;
      // a row left of z = 0 wraps and shows as a set top bit
      acc_ok    = !zn_acc[8] && (zn_acc[7:0] < cur_zsize);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (&clr_addr_ff) begin
               state_in = reply_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (op_type'(req_op))
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_MARK:  state_in = new_in_grid ? ST_MARK_RD : ST_DONE;
                  OP_QUERY: state_in = new_in_grid ? ST_QUERY : ST_DONE;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_MARK_RD: state_in = ST_MARK_WR;
         ST_MARK_WR: state_in = ST_DONE;
         ST_QUERY: begin
            if (step_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory control and datapath register updates
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = {sec_ff, z_ff[ZW-1:0]};
      wr_data  = rd_data | ({{(ROW_W-1){1'b0}}, 1'b1} << y_ff);
      rd_addr  = {sec_ff, zn_issue[ZW-1:0]};

      clr_addr_in = clr_addr_ff;
      step_in     = step_ff;
      reply_in    = reply_ff;
      op_in       = op_ff;
      sec_in      = sec_ff;
      z_in        = z_ff;
      y_in        = y_ff;
      prior_in    = prior_ff;
      err_in      = err_ff;
      mask_in     = mask_ff;
      count_in    = count_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               op_in       = req_op;
               sec_in      = new_sec;
               z_in        = req_tower_z;
               y_in        = req_tower_y;
               prior_in    = req_prior_deadmap;
               mask_in     = '0;
               step_in     = '0;
               clr_addr_in = '0;
               reply_in    = 1'b1;
               err_in      = 1'b0;
               case (op_type'(req_op)) inside
                  OP_CLEAR:           count_in = '0;
                  OP_MARK, OP_QUERY:  err_in   = !new_in_grid;
                  default:            err_in   = 1'b0;
               endcase
            end
         end
         ST_MARK_RD: begin
            rd_addr = {sec_ff, z_ff[ZW-1:0]};
         end
         ST_MARK_WR: begin
            wr_en = 1'b1;
            if (!(&count_ff)) begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_QUERY: begin
            step_in = step_ff + 1'b1;
            // the row read at the previous step arrives now
            if (step_ff != '0) begin
               mask_in = mask_ff | contrib;
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         reply_ff    <= 1'b0;
         count_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         reply_ff    <= reply_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      op_ff    <= op_in;
      sec_ff   <= sec_in;
      z_ff     <= z_in;
      y_ff     <= y_in;
      prior_ff <= prior_in;
      err_ff   <= err_in;
      mask_ff  <= mask_in;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      is_query = (op_type'(op_ff) == OP_QUERY);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_mask_ff   <= is_query ? mask_ff : '0;
         rsp_merged_ff <= !is_query ? '0
                          : cur_glass ? (prior_ff | MAP_W'(mask_ff)) : MAP_W'(mask_ff);
         rsp_dead_ff   <= is_query && cur_glass;
         rsp_sec_ff    <= is_query ? sec_ff : '0;
         rsp_count_ff  <= count_ff;
         rsp_err_ff    <= err_ff;
      end
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_neighbor_mask = rsp_mask_ff;
   assign rsp_merged_map    = rsp_merged_ff;
   assign rsp_to_deadmap    = rsp_dead_ff;
   assign rsp_hw_sector     = rsp_sec_ff;
   assign rsp_bad_count     = rsp_count_ff;
   assign rsp_range_error   = rsp_err_ff;

   trnm_bitmap #(
      .ADDR_W (ADDR_W),
      .ROW_W  (ROW_W)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   trnm_window #(
      .ROW_W (ROW_W)
   ) u_window (
      .row     (rd_data),
      .row_ok  (acc_ok),
      .tower_y (y_ff),
      .step    (step_acc),
      .contrib (contrib)
   );

   // a result only leaves the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done state");

   // the count only drops on reset or an accepted clear
   a_count_drop: assert property (@(posedge clock) disable iff (reset)
      (count_ff < $past(count_ff)) |->
         ($past(reset) || $past(accept && (op_type'(req_op) == OP_CLEAR))))
      else $error("reject count dropped without a clear");

   // deadmap results only come from glass sectors
   a_dead_glass: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_dead_ff) |-> (rsp_sec_ff >= FIRST_GLASS))
      else $error("deadmap result from a non-glass sector");

   // a range error carries no neighbour bits
   a_err_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_mask_ff == '0))
      else $error("neighbour mask set on a range error");

endmodule

// File: verif/tower_reject_neighbor_map_test.sv
// self-checking testbench for tower_reject_neighbor_map: directed and random clear, mark and
// query transactions with an in-bench predictor of the bad-tower map and the reject count
// depends on trnm_pkg and the rtl of the block
module tower_reject_neighbor_map_test;
   timeunit 1ns;
   timeprecision 1ps;
   import trnm_pkg::*;

   localparam int GLASS_Z      = 96;
   localparam int GLASS_Y      = 48;
   localparam int SCINT_Z      = 72;
   localparam int SCINT_Y      = 36;
   localparam logic [COUNT_W-1:0] COUNT_CEIL = 16'hFFFF;
   localparam int RANDOM_ITEMS = 1500;
   localparam int SETTLE_CYCLES = 16;
   localparam int LIMIT_CYCLES = 3_000_000;
   // hardware sector for each software sector, three bits per entry
   localparam logic [23:0] HW_OF_SW = {3'd5, 3'd4, 3'd7, 3'd6, 3'd3, 3'd2, 3'd1, 3'd0};

   typedef struct packed {
      op_type                op;
      logic [SECTOR_W-1:0]   load_sector;
      logic                  arm;
      logic [1:0]            arm_sector;
      logic [TOWER_Z_W-1:0]  tower_z;
      logic [TOWER_Y_W-1:0]  tower_y;
      logic [MAP_W-1:0]      prior_deadmap;
      logic [1:0]            gap;
      logic                  drain;
   } tower_req_type;

   typedef struct packed {
      logic [MASK_W-1:0]     neighbor_mask;
      logic [MAP_W-1:0]      merged_map;
      logic                  to_deadmap;
      logic [SECTOR_W-1:0]   hw_sector;
      logic [COUNT_W-1:0]    bad_count;
      logic                  range_error;
   } tower_rsp_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_op = 2'd0;
   logic [SECTOR_W-1:0]  req_load_sector = '0;
   logic                 req_arm = 1'b0;
   logic [1:0]           req_arm_sector = '0;
   logic [TOWER_Z_W-1:0] req_tower_z = '0;
   logic [TOWER_Y_W-1:0] req_tower_y = '0;
   logic [MAP_W-1:0]     req_prior_deadmap = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [MASK_W-1:0]    rsp_neighbor_mask;
   logic [MAP_W-1:0]     rsp_merged_map;
   logic                 rsp_to_deadmap;
   logic [SECTOR_W-1:0]  rsp_hw_sector;
   logic [COUNT_W-1:0]   rsp_bad_count;
   logic                 rsp_range_error;

   tower_req_type pending_items[$];
   tower_rsp_type expected_results[$];
   tower_req_type current_item;
   int idle_count = 0;
   int stall_left = 0;
   int results_taken = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int gap_max = 3;
   bit drain_next = 1'b0;

   // predicted state of the block
   bit [63:0]          reject_map [NUM_SECTORS][128];
   logic [COUNT_W-1:0] reject_tally = '0;

   tower_reject_neighbor_map #(
      .MAX_Z_TOWERS(GLASS_Z),
      .MAX_Y_TOWERS(GLASS_Y),
      .SCINT_Z_TOWERS(SCINT_Z),
      .SCINT_Y_TOWERS(SCINT_Y)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_load_sector(req_load_sector),
      .req_arm(req_arm),
      .req_arm_sector(req_arm_sector),
      .req_tower_z(req_tower_z),
      .req_tower_y(req_tower_y),
      .req_prior_deadmap(req_prior_deadmap),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_neighbor_mask(rsp_neighbor_mask),
      .rsp_merged_map(rsp_merged_map),
      .rsp_to_deadmap(rsp_to_deadmap),
      .rsp_hw_sector(rsp_hw_sector),
      .rsp_bad_count(rsp_bad_count),
      .rsp_range_error(rsp_range_error)
   );

   always #1 clock = ~clock;

   function automatic int grid_z(input logic [SECTOR_W-1:0] s);
      return (s >= FIRST_GLASS) ? GLASS_Z : SCINT_Z;
   endfunction

   function automatic int grid_y(input logic [SECTOR_W-1:0] s);
      return (s >= FIRST_GLASS) ? GLASS_Y : SCINT_Y;
   endfunction

   function automatic bit in_grid(input logic [SECTOR_W-1:0] s, input int z, input int y);
      return z >= 0 && y >= 0 && z < grid_z(s) && y < grid_y(s);
   endfunction

   function automatic bit tower_bad(input logic [SECTOR_W-1:0] s, input int z, input int y);
      if (!in_grid(s, z, y)) return 1'b0;
      return reject_map[s][z][y];
   endfunction

   // advances the predicted map by one transaction and returns the result it should give
   function automatic tower_rsp_type apply_item(input tower_req_type it);
      tower_rsp_type r;
      int z, y, bit_at;
      r = '0;
      z = it.tower_z;
      y = it.tower_y;
      case (it.op)
         OP_CLEAR: begin
            for (int s = 0; s < NUM_SECTORS; s++)
               for (int zz = 0; zz < 128; zz++) reject_map[s][zz] = '0;
            reject_tally = '0;
         end
         OP_MARK: begin
            if (in_grid(it.load_sector, z, y)) begin
               reject_map[it.load_sector][z][y] = 1'b1;
               if (reject_tally != COUNT_CEIL) reject_tally = reject_tally + 1'b1;
            end else begin
               r.range_error = 1'b1;
            end
         end
         OP_QUERY: begin
            r.hw_sector = HW_OF_SW[{it.arm, it.arm_sector} * 3 +: 3];
            if (in_grid(r.hw_sector, z, y)) begin
               for (int dy = -2; dy <= 2; dy++) begin
                  for (int dz = -2; dz <= 2; dz++) begin
                     if (dy == -2 || dy == 2) begin
                        // 5x5 corners are not part of the mask
                        if (dz != -2 && dz != 2) begin
                           bit_at = ((dy < 0) ? 0 : TOP_ROW_BASE) + dz + 1;
                           r.neighbor_mask[bit_at] = tower_bad(r.hw_sector, z + dz, y + dy);
                        end
                     end else begin
                        bit_at = 3 + ROW_SPAN * (dy + 1) + dz + 2;
                        r.neighbor_mask[bit_at] = tower_bad(r.hw_sector, z + dz, y + dy);
                     end
                  end
               end
            end else begin
               r.range_error = 1'b1;
            end
            if (r.hw_sector >= FIRST_GLASS) begin
               r.to_deadmap = 1'b1;
               r.merged_map = it.prior_deadmap | MAP_W'(r.neighbor_mask);
            end else begin
               r.merged_map = MAP_W'(r.neighbor_mask);
            end
         end
         default: ;
      endcase
      r.bad_count = reject_tally;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic queue_item(input op_type op, input logic [SECTOR_W-1:0] lsec,
                             input logic [2:0] sw, input int z, input int y,
                             input logic [MAP_W-1:0] prior);
      tower_req_type it;
      it.op            = op;
      it.load_sector   = lsec;
      it.arm           = sw[2];
      it.arm_sector    = sw[1:0];
      it.tower_z       = TOWER_Z_W'(z);
      it.tower_y       = TOWER_Y_W'(y);
      it.prior_deadmap = prior;
      it.gap           = 2'($urandom_range(0, gap_max));
      it.drain         = drain_next;
      drain_next = 1'b0;
      pending_items.push_back(it);
   endtask

   task automatic queue_mark(input logic [SECTOR_W-1:0] hw, input int z, input int y);
      queue_item(OP_MARK, hw, 3'($urandom), z, y, $urandom);
   endtask

   task automatic queue_query(input logic [2:0] sw, input int z, input int y,
                              input logic [MAP_W-1:0] prior);
      queue_item(OP_QUERY, 3'($urandom), sw, z, y, prior);
   endtask

   // biased towards the edges of the sector grid
   function automatic int pick_coord(input int n);
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 1;
         2:       return n - 2;
         3:       return n - 1;
         default: return $urandom_range(0, n - 1);
      endcase
   endfunction

   // driver: one transaction per pending item, after its drawn gap
   always @(posedge clock) begin : drive_requests
      logic launch;
      logic slot_free;
      launch = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
         idle_count = 0;
      end else begin
         slot_free = !req_valid || !req_stall;
         if (req_valid && !req_stall) expected_results.push_back(apply_item(current_item));
         if (slot_free) begin
            if (pending_items.size() != 0 &&
                !(pending_items[0].drain && expected_results.size() != 0)) begin
               if (idle_count < pending_items[0].gap) begin
                  idle_count++;
               end else begin
                  current_item = pending_items.pop_front();
                  idle_count = 0;
                  launch = 1'b1;
               end
            end
            req_valid <= launch;
            if (launch) begin
               req_op            <= current_item.op;
               req_load_sector   <= current_item.load_sector;
               req_arm           <= current_item.arm;
               req_arm_sector    <= current_item.arm_sector;
               req_tower_z       <= current_item.tower_z;
               req_tower_y       <= current_item.tower_y;
               req_prior_deadmap <= current_item.prior_deadmap;
            end
         end
      end
   end

   // monitor: checks each result, then may hold off the next one with a randomly drawn stall
   always @(posedge clock) begin : check_results
      tower_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_neighbor_mask, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_neighbor_mask !== want.neighbor_mask)
                  report_mismatch("neighbor_mask", rsp_neighbor_mask, want.neighbor_mask);
               if (rsp_merged_map !== want.merged_map)
                  report_mismatch("merged_map", rsp_merged_map, want.merged_map);
               if (rsp_to_deadmap !== want.to_deadmap)
                  report_mismatch("to_deadmap", rsp_to_deadmap, want.to_deadmap);
               if (rsp_hw_sector !== want.hw_sector)
                  report_mismatch("hw_sector", rsp_hw_sector, want.hw_sector);
               if (rsp_bad_count !== want.bad_count)
                  report_mismatch("bad_count", rsp_bad_count, want.bad_count);
               if (rsp_range_error !== want.range_error)
                  report_mismatch("range_error", rsp_range_error, want.range_error);
            end
            results_taken++;
            // quiet stretch with no back-pressure now and then
            stall_left = (results_taken % 500 >= 350) ? 0 : $urandom_range(0, 3);
         end else if (rsp_valid && stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : stimulus
      logic [2:0]          sw;
      logic [SECTOR_W-1:0] hw;
      int cz, cy, dz, dy, episode, start_size;

      // directed: grid extremes, out-of-range marks and queries, repeat marks, plus pattern
      queue_query(3'd4, 0, 0, 32'hFFFF_FFFF);
      queue_mark(3'd0, 0, 0);
      queue_mark(3'd0, SCINT_Z - 1, SCINT_Y - 1);
      queue_mark(3'd7, GLASS_Z - 1, GLASS_Y - 1);
      queue_mark(3'd6, GLASS_Z, 0);
      queue_mark(3'd0, SCINT_Z, 0);
      queue_mark(3'd5, 0, SCINT_Y);
      queue_mark(3'd7, 127, 63);
      queue_mark(3'd0, 0, 0);
      queue_query(3'd0, 0, 0, 32'hDEAD_BEEF);
      queue_query(3'd5, GLASS_Z - 1, GLASS_Y - 1, 32'h0);
      queue_query(3'd0, SCINT_Z, 0, 32'h1234_5678);
      queue_query(3'd5, 127, 63, 32'hFFFF_FFFF);
      queue_mark(3'd3, 9, 8);
      queue_mark(3'd3, 12, 10);
      queue_mark(3'd3, 8, 11);
      queue_mark(3'd3, 11, 12);
      queue_mark(3'd3, 12, 12);
      queue_query(3'd3, 10, 10, $urandom);
      queue_query(3'd1, 10, 10, $urandom);
      queue_item(OP_NONE, 3'($urandom), 3'($urandom), 127, 63, 32'hFFFF_FFFF);
      queue_query(3'd6, SCINT_Z - 1, SCINT_Y - 1, 32'hFFFF_FFFF);
      drain_next = 1'b1;
      queue_item(OP_CLEAR, 3'($urandom), 3'($urandom), $urandom_range(0, 127),
                 $urandom_range(0, 63), $urandom);
      queue_query(3'd3, 10, 10, $urandom);

      // random: marks around a centre then a query of it, with some noise
      start_size = pending_items.size();
      episode = 0;
      while (pending_items.size() - start_size < RANDOM_ITEMS) begin
         gap_max = (episode % 6 == 5) ? 0 : 3;
         drain_next = (episode % 150 == 149);
         if (episode % 120 == 119)
            queue_item(OP_CLEAR, 3'($urandom), 3'($urandom), $urandom_range(0, 127),
                       $urandom_range(0, 63), $urandom);
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3))
               queue_item(op_type'($urandom_range(1, 3)), 3'($urandom), 3'($urandom),
                          $urandom_range(0, 127), $urandom_range(0, 63), $urandom);
         end else begin
            sw = 3'($urandom);
            hw = HW_OF_SW[sw * 3 +: 3];
            cz = pick_coord(grid_z(hw));
            cy = pick_coord(grid_y(hw));
            repeat ($urandom_range(0, 6)) begin
               dz = $urandom_range(0, 4);
               dy = $urandom_range(0, 4);
               queue_mark(hw, cz + dz - 2, cy + dy - 2);
            end
            queue_query(sw, cz, cy, $urandom);
            if ($urandom_range(0, 2) == 0) begin
               dz = $urandom_range(0, 2);
               dy = $urandom_range(0, 2);
               queue_query(sw, cz + dz - 1, cy + dy - 1, $urandom);
            end
         end
         episode++;
      end

      // clear after a full drain, then a few items around it
      gap_max = 0;
      drain_next = 1'b1;
      queue_item(OP_CLEAR, 3'($urandom), 3'($urandom), 0, 0, $urandom);
      gap_max = 3;
      queue_query(3'($urandom), 5, 5, $urandom);
      queue_mark(3'd6, 0, 0);
      queue_mark(3'd2, SCINT_Z, SCINT_Y);
      queue_query(3'd4, 1, 1, $urandom);
      queue_item(OP_CLEAR, 3'($urandom), 3'($urandom), 0, 0, $urandom);
      queue_query(3'd4, 1, 1, $urandom);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: tower_reject_neighbor_map.f
rtl/trnm_pkg.sv
rtl/trnm_bitmap.sv
rtl/trnm_window.sv
rtl/tower_reject_neighbor_map.sv
verif/tower_reject_neighbor_map_test.sv
